### hw/rtl/cu_pkg.sv
// ----------------------------------------------------------------------------
// cu_pkg: shared types and constants for the console UART
// Request and result structs, FIFO sizes, bus and CSR codes, digit helpers.
// ----------------------------------------------------------------------------
package cu_pkg;

  // FIFO depths and the widths that follow from them.
  localparam int RX_DEPTH = 16384;
  localparam int TX_DEPTH = 65536;
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int RX_LW = $clog2(RX_DEPTH + 1);
  localparam int RX_SW = RX_AW + 2;
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int TX_LW = $clog2(TX_DEPTH + 1);
  localparam int TX_SW = TX_AW + 2;

  // Request opcodes.
  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_STORE  = 3'd1;
  localparam logic [2:0] OP_CSR_WR = 3'd2;
  localparam logic [2:0] OP_CSR_RD = 3'd3;
  localparam logic [2:0] OP_PUSH   = 3'd4;
  localparam logic [2:0] OP_POP    = 3'd5;

  // Guest bus addresses and CSR numbers.
  localparam logic [31:0] DATA_ADDR      = 32'h1000_0000;
  localparam logic [31:0] STATUS_ADDR    = 32'h1000_0005;
  localparam logic [7:0]  STATUS_BASE    = 8'h60;
  localparam logic [11:0] CSR_PRINT_DEC  = 12'h136;
  localparam logic [11:0] CSR_PRINT_HEX  = 12'h137;
  localparam logic [11:0] CSR_PRINT_BYTE = 12'h139;
  localparam logic [11:0] CSR_GET_BYTE   = 12'h140;
  localparam logic [8:0]  RD_NONE        = 9'h1FF;

  // Digit counts for the print commands.
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W = 4 * BCD_DIGITS;
  localparam int BIN_W = 32;
  localparam logic [3:0] DEC_COUNT = 4'd10;
  localparam logic [3:0] HEX_COUNT = 4'd8;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] address;
    logic [11:0] csr_sel;
    logic [31:0] data_value;
  } cu_req_t;

  typedef struct packed {
    logic signed [8:0] read_data;
    logic              push_accepted;
    logic              pop_valid;
    logic [7:0]        pop_byte;
  } cu_rsp_t;

  // ASCII character for one hex or decimal digit, lowercase letters.
  function automatic logic [7:0] cu_digit_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h57 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

### hw/rtl/cu_ram.sv
// ----------------------------------------------------------------------------
// cu_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cu_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; read data is registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/cu_bcd.sv
// ----------------------------------------------------------------------------
// cu_bcd: binary to BCD converter
// Shift-and-add-3 conversion of a 32-bit value, one bit per cycle.
// ----------------------------------------------------------------------------
module cu_bcd (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [31:0]              value,
  output logic                     done,
  output logic [cu_pkg::BCD_W-1:0] bcd
);
  import cu_pkg::*;

  logic [BIN_W-1:0] bin;
  logic [5:0]       cnt;
  logic             running;
  logic [BCD_W-1:0] adj;

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // Conversion sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        bin     <= value;
        bcd     <= '0;
        cnt     <= 6'(BIN_W);
        running <= 1'b1;
      end else if (running) begin
        bcd <= {adj[BCD_W-2:0], bin[BIN_W-1]};
        bin <= {bin[BIN_W-2:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/console_uart_with_fifos.sv
// ----------------------------------------------------------------------------
// console_uart_with_fifos: console device with receive and transmit FIFOs
// Guest loads and stores, CSR reads and prints, and host push and pop on
// two byte-wide FIFOs held in synchronous RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   --------  --------------------  ------------------
//   request   start high, busy low  request (cu_req_t)
//   result    done, one cycle       result  (cu_rsp_t)
//
// Status reads, stores, byte prints and host pushes are answered from the idle state.
// Loads, CSR reads and host pops that read a FIFO wait in S_RX_WAIT or S_TX_WAIT for RAM data.
// A decimal print runs the BCD conversion (S_BCD), drops leading zero digits
// while keeping at least one (S_TRIM), then writes one byte per digit (S_EMIT);
// a hex print writes all eight digits in S_EMIT, one write each.
// Reset is synchronous and empties both FIFOs; no clearing pass is needed.
// busy stays high until the result strobe; results cannot be held off.
module console_uart_with_fifos (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  cu_pkg::cu_req_t request,
  output logic            done,
  output cu_pkg::cu_rsp_t result
);
  import cu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RX_WAIT,
    S_TX_WAIT,
    S_BCD,
    S_TRIM,
    S_EMIT
  } state_t;

  state_t state;

  logic [RX_AW-1:0] rx_head;
  logic [RX_LW-1:0] rx_level;
  logic [TX_AW-1:0] tx_head;
  logic [TX_LW-1:0] tx_level;

  logic [BCD_W-1:0] emit_val;
  logic [3:0]       emit_cnt;

  logic             accept;
  logic             rx_we;
  logic             rx_re;
  logic             tx_re;
  logic             tx_put;
  logic [7:0]       tx_byte;
  logic             bcd_go;
  logic             hex_go;
  logic [8:0]       idle_rd;
  logic [7:0]       rx_rdata;
  logic [7:0]       tx_rdata;
  logic             bcd_done;
  logic [BCD_W-1:0] bcd_value;

  logic [RX_SW-1:0] rx_sum;
  logic [RX_AW-1:0] rx_slot;
  logic [RX_AW-1:0] rx_head_inc;
  logic [TX_SW-1:0] tx_sum;
  logic [TX_AW-1:0] tx_slot;
  logic [TX_AW-1:0] tx_head_inc;
  logic             rx_empty;
  logic             rx_full;
  logic             tx_empty;
  logic             tx_full;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // FIFO pointer arithmetic with wrap at the depth.
  always_comb begin
    rx_sum = {2'b00, rx_head} + RX_SW'(rx_level);
    if (rx_sum >= RX_SW'(RX_DEPTH)) begin
      rx_sum = rx_sum - RX_SW'(RX_DEPTH);
    end
    rx_slot = rx_sum[RX_AW-1:0];
    if (rx_head == RX_AW'(RX_DEPTH - 1)) begin
      rx_head_inc = '0;
    end else begin
      rx_head_inc = rx_head + RX_AW'(1);
    end

    tx_sum = {2'b00, tx_head} + TX_SW'(tx_level);
    if (tx_sum >= TX_SW'(TX_DEPTH)) begin
      tx_sum = tx_sum - TX_SW'(TX_DEPTH);
    end
    tx_slot = tx_sum[TX_AW-1:0];
    if (tx_head == TX_AW'(TX_DEPTH - 1)) begin
      tx_head_inc = '0;
    end else begin
      tx_head_inc = tx_head + TX_AW'(1);
    end

    rx_empty = (rx_level == '0);
    rx_full  = (rx_level == RX_LW'(RX_DEPTH));
    tx_empty = (tx_level == '0);
    tx_full  = (tx_level == TX_LW'(TX_DEPTH));
  end

  // Request decode and FIFO port control.
  always_comb begin
    rx_we   = 1'b0;
    rx_re   = 1'b0;
    tx_re   = 1'b0;
    tx_put  = 1'b0;
    tx_byte = request.data_value[7:0];
    bcd_go  = 1'b0;
    hex_go  = 1'b0;
    idle_rd = '0;
    if (accept) begin
      case (request.opcode)
        OP_LOAD: begin
          if (request.address == STATUS_ADDR) begin
            idle_rd = {1'b0, STATUS_BASE | {7'h00, !rx_empty}};
          end else if (request.address == DATA_ADDR) begin
            rx_re = !rx_empty;
          end
        end
        OP_STORE: begin
          tx_put = (request.address == DATA_ADDR);
        end
        OP_CSR_WR: begin
          bcd_go = (request.csr_sel == CSR_PRINT_DEC);
          hex_go = (request.csr_sel == CSR_PRINT_HEX);
          tx_put = (request.csr_sel == CSR_PRINT_BYTE);
        end
        OP_CSR_RD: begin
          if (request.csr_sel == CSR_GET_BYTE) begin
            rx_re = !rx_empty;
            if (rx_empty) begin
              idle_rd = RD_NONE;
            end
          end
        end
        OP_PUSH: begin
          rx_we = !rx_full;
        end
        OP_POP: begin
          tx_re = !tx_empty;
        end
        default: begin
        end
      endcase
    end
    if (state == S_EMIT) begin
      tx_put  = 1'b1;
      tx_byte = cu_digit_char(emit_val[BCD_W-1 -: 4]);
    end
  end

  // Receive FIFO storage.
  cu_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_slot),
    .wdata (request.data_value[7:0]),
    .re    (rx_re),
    .raddr (rx_head),
    .rdata (rx_rdata)
  );

  // Transmit FIFO storage; a put into a full FIFO overwrites the oldest slot.
  cu_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx_ram (
    .clk   (clk),
    .we    (tx_put),
    .waddr (tx_slot),
    .wdata (tx_byte),
    .re    (tx_re),
    .raddr (tx_head),
    .rdata (tx_rdata)
  );

  // Decimal digit generation.
  cu_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .go    (bcd_go),
    .value (request.data_value),
    .done  (bcd_done),
    .bcd   (bcd_value)
  );

  // Sequencer, FIFO pointers and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      rx_head  <= '0;
      rx_level <= '0;
      tx_head  <= '0;
      tx_level <= '0;
      emit_cnt <= '0;
    end else begin
      done <= 1'b0;

      if (rx_we) begin
        rx_level <= rx_level + RX_LW'(1);
      end else if (rx_re) begin
        rx_head  <= rx_head_inc;
        rx_level <= rx_level - RX_LW'(1);
      end

      if (tx_put) begin
        if (tx_full) begin
          tx_head <= tx_head_inc;
        end else begin
          tx_level <= tx_level + TX_LW'(1);
        end
      end else if (tx_re) begin
        tx_head  <= tx_head_inc;
        tx_level <= tx_level - TX_LW'(1);
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (rx_re) begin
              state <= S_RX_WAIT;
            end else if (tx_re) begin
              state <= S_TX_WAIT;
            end else if (bcd_go) begin
              state <= S_BCD;
            end else if (hex_go) begin
              emit_val <= {request.data_value, 8'h00};
              emit_cnt <= HEX_COUNT;
              state    <= S_EMIT;
            end else begin
              result <= '{read_data: idle_rd, push_accepted: rx_we,
                          pop_valid: 1'b0, pop_byte: 8'h00};
              done   <= 1'b1;
            end
          end
        end
        S_RX_WAIT: begin
          result <= '{read_data: {1'b0, rx_rdata}, push_accepted: 1'b0,
                      pop_valid: 1'b0, pop_byte: 8'h00};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_TX_WAIT: begin
          result <= '{read_data: 9'h000, push_accepted: 1'b0,
                      pop_valid: 1'b1, pop_byte: tx_rdata};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_BCD: begin
          if (bcd_done) begin
            emit_val <= bcd_value;
            emit_cnt <= DEC_COUNT;
            state    <= S_TRIM;
          end
        end
        S_TRIM: begin
          // Drop leading zero digits, keeping at least one.
          if (emit_val[BCD_W-1 -: 4] == 4'h0 && emit_cnt > 4'd1) begin
            emit_val <= {emit_val[BCD_W-5:0], 4'h0};
            emit_cnt <= emit_cnt - 4'd1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          emit_val <= {emit_val[BCD_W-5:0], 4'h0};
          emit_cnt <= emit_cnt - 4'd1;
          if (emit_cnt == 4'd1) begin
            result <= '0;
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sim/tb_console_uart_with_fifos.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_console_uart_with_fifos: self-checking bench for the console UART
// Sends guest, CSR and host requests, predicts every result with a
// behavioral copy of both FIFOs, and checks each result strobe in order.
// ----------------------------------------------------------------------------
module tb_console_uart_with_fifos;
  import cu_pkg::*;

  // Opcodes the block does not define; they must return all zeros.
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int RX_BURST     = 100;
  localparam int TX_PRINTS    = 20;
  localparam int RANDOM_ITEMS = 1140;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 500000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cu_req_t request = '0;
  logic    busy;
  logic    done;
  cu_rsp_t result;

  // Behavioral copy of the two FIFOs.
  logic [7:0] rx_bytes [RX_DEPTH];
  logic [7:0] tx_bytes [TX_DEPTH];
  int rx_head = 0;
  int rx_level = 0;
  int tx_head = 0;
  int tx_level = 0;

  // Results predicted for accepted requests, oldest first.
  cu_rsp_t pending_results [$];
  cu_rsp_t oldest_result;

  int gap_limit = 15;
  bit drain_mode = 1'b0;
  int mismatches = 0;
  int results_seen = 0;
  int tick_count = 0;
  int rx_refused = 0;
  int tx_dropped = 0;
  int op_count [8];

  console_uart_with_fifos dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #6 clk = ~clk;

  // Queue one byte for transmit; a full FIFO loses its oldest byte first.
  task automatic tx_enqueue(input logic [7:0] b);
    if (tx_level >= TX_DEPTH) begin
      tx_head = (tx_head + 1) % TX_DEPTH;
      tx_level = TX_DEPTH - 1;
      tx_dropped++;
    end
    tx_bytes[(tx_head + tx_level) % TX_DEPTH] = b;
    tx_level++;
  endtask

  // Take the oldest received byte; only called with bytes waiting.
  function automatic logic [7:0] rx_dequeue();
    logic [7:0] b;
    b = rx_bytes[rx_head];
    rx_head = (rx_head + 1) % RX_DEPTH;
    rx_level--;
    return b;
  endfunction

  // Compute the result of one request and advance the FIFO copies.
  task automatic console_predict(input cu_req_t r, output cu_rsp_t rsp);
    logic [7:0] digs [10];
    logic [31:0] v;
    logic [3:0] nib;
    int n;
    int i;
    rsp = '0;
    case (r.opcode)
      OP_LOAD: begin
        if (r.address == STATUS_ADDR) begin
          rsp.read_data = {1'b0, STATUS_BASE | {7'd0, rx_level != 0}};
        end else if (r.address == DATA_ADDR && rx_level != 0) begin
          rsp.read_data = {1'b0, rx_dequeue()};
        end
      end
      OP_STORE: begin
        if (r.address == DATA_ADDR) tx_enqueue(r.data_value[7:0]);
      end
      OP_CSR_WR: begin
        if (r.csr_sel == CSR_PRINT_DEC) begin
          // Digits come out least significant first, so queue them reversed.
          v = r.data_value;
          for (n = 0; n == 0 || (v != 0 && n < 10); n++) begin
            digs[n] = 8'h30 + 8'(v % 32'd10);
            v = v / 32'd10;
          end
          for (i = n - 1; i >= 0; i--) tx_enqueue(digs[i]);
        end else if (r.csr_sel == CSR_PRINT_HEX) begin
          for (i = 7; i >= 0; i--) begin
            nib = r.data_value[4*i +: 4];
            tx_enqueue(nib < 4'd10 ? 8'h30 + nib : 8'h61 + nib - 8'd10);
          end
        end else if (r.csr_sel == CSR_PRINT_BYTE) begin
          tx_enqueue(r.data_value[7:0]);
        end
      end
      OP_CSR_RD: begin
        if (r.csr_sel == CSR_GET_BYTE) begin
          rsp.read_data = (rx_level != 0) ? {1'b0, rx_dequeue()} : RD_NONE;
        end
      end
      OP_PUSH: begin
        if (rx_level < RX_DEPTH) begin
          rx_bytes[(rx_head + rx_level) % RX_DEPTH] = r.data_value[7:0];
          rx_level++;
          rsp.push_accepted = 1'b1;
        end else begin
          rx_refused++;
        end
      end
      OP_POP: begin
        if (tx_level != 0) begin
          rsp.pop_byte = tx_bytes[tx_head];
          rsp.pop_valid = 1'b1;
          tx_head = (tx_head + 1) % TX_DEPTH;
          tx_level--;
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic cu_req_t build_request(input logic [2:0] op,
                                            input logic [31:0] addr,
                                            input logic [11:0] csr,
                                            input logic [31:0] val);
    cu_req_t r;
    r.opcode = op;
    r.address = addr;
    r.csr_sel = csr;
    r.data_value = val;
    return r;
  endfunction

  // Present one request after a random gap and record its expected result once
  // it is taken. start stays high when the next request follows with no gap.
  task automatic send_request(input cu_req_t r);
    int gap;
    cu_rsp_t rsp;
    gap = $urandom_range(0, gap_limit);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    console_predict(r, rsp);
    pending_results.push_back(rsp);
    op_count[r.opcode]++;
  endtask

  // Hold off new requests until every outstanding result has arrived.
  task automatic pause_until_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random request, weighted toward the addresses and CSRs that do something.
  function automatic cu_req_t random_request();
    logic [2:0] ops [7];
    int wts [7];
    cu_req_t r;
    int p;
    int k;
    ops = '{OP_LOAD, OP_STORE, OP_CSR_WR, OP_CSR_RD, OP_PUSH, OP_POP, OP_RSVD6};
    if (drain_mode) wts = '{20, 5, 5, 15, 20, 30, 5};
    else wts = '{12, 14, 14, 10, 25, 20, 5};
    p = $urandom_range(0, 99);
    r.opcode = ops[6];
    for (k = 0; k < 7; k++) begin
      if (p < wts[k]) begin
        r.opcode = ops[k];
        break;
      end
      p -= wts[k];
    end
    if (r.opcode == OP_RSVD6 && $urandom_range(0, 1) == 1) r.opcode = OP_RSVD7;

    p = $urandom_range(0, 99);
    if (p < 45) r.address = DATA_ADDR;
    else if (p < 75) r.address = STATUS_ADDR;
    else if (p < 85) r.address = DATA_ADDR ^ (32'd1 << $urandom_range(0, 31));
    else r.address = $urandom;

    p = $urandom_range(0, 99);
    if (r.opcode == OP_CSR_RD) begin
      if (p < 70) r.csr_sel = CSR_GET_BYTE;
      else if (p < 85) r.csr_sel = CSR_PRINT_HEX;
      else r.csr_sel = $urandom_range(0, 4095);
    end else begin
      if (p < 25) r.csr_sel = CSR_PRINT_DEC;
      else if (p < 50) r.csr_sel = CSR_PRINT_HEX;
      else if (p < 80) r.csr_sel = CSR_PRINT_BYTE;
      else if (p < 85) r.csr_sel = CSR_GET_BYTE;
      else r.csr_sel = $urandom_range(0, 4095);
    end

    // Mix of widths so decimal prints get every digit count.
    p = $urandom_range(0, 99);
    if (p < 60) r.data_value = $urandom;
    else if (p < 75) r.data_value = $urandom_range(0, 99);
    else if (p < 85) r.data_value = $urandom >> $urandom_range(0, 31);
    else begin
      case ($urandom_range(0, 3))
        0: r.data_value = 32'd0;
        1: r.data_value = 32'hFFFF_FFFF;
        2: r.data_value = 32'd999999999;
        default: r.data_value = 32'd1000000000;
      endcase
    end
    return r;
  endfunction

  // Edge cases: empty FIFOs, byte extremes, every opcode and print format.
  task automatic test_directed();
    int k;
    send_request(build_request(OP_LOAD, STATUS_ADDR, 12'h000, 32'h0));
    send_request(build_request(OP_LOAD, DATA_ADDR, 12'h000, 32'h0));
    send_request(build_request(OP_CSR_RD, 32'h0, CSR_GET_BYTE, 32'h0));
    send_request(build_request(OP_POP, 32'h0, 12'h000, 32'h0));
    send_request(build_request(OP_PUSH, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FF00));
    send_request(build_request(OP_PUSH, 32'h0, 12'h000, 32'h0000_00FF));
    send_request(build_request(OP_LOAD, STATUS_ADDR, 12'h000, 32'h0));
    send_request(build_request(OP_LOAD, 32'hFFFF_FFFF, 12'h000, 32'h0));
    send_request(build_request(OP_LOAD, 32'h0, 12'h000, 32'h0));
    send_request(build_request(OP_CSR_RD, 32'h0, 12'hFFF, 32'h0));
    send_request(build_request(OP_LOAD, DATA_ADDR, 12'h000, 32'hFFFF_FFFF));
    send_request(build_request(OP_CSR_RD, 32'h0, CSR_GET_BYTE, 32'h0));
    send_request(build_request(OP_STORE, DATA_ADDR, 12'h000, 32'hFFFF_FFA5));
    send_request(build_request(OP_STORE, DATA_ADDR | 32'h1, 12'h000, 32'h0000_0041));
    send_request(build_request(OP_CSR_WR, 32'h0, CSR_PRINT_DEC, 32'h0));
    send_request(build_request(OP_CSR_WR, 32'h0, CSR_PRINT_DEC, 32'hFFFF_FFFF));
    send_request(build_request(OP_CSR_WR, 32'h0, CSR_PRINT_HEX, 32'h0));
    send_request(build_request(OP_CSR_WR, 32'h0, CSR_PRINT_HEX, 32'hFEDC_BA98));
    send_request(build_request(OP_CSR_WR, 32'h0, CSR_PRINT_BYTE, 32'h1234_5680));
    send_request(build_request(OP_CSR_WR, 32'h0, 12'h000, 32'h0000_0042));
    send_request(build_request(OP_RSVD6, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF));
    send_request(build_request(OP_RSVD7, DATA_ADDR, CSR_GET_BYTE, 32'hFFFF_FFFF));
    for (k = 0; k < 4; k++) send_request(build_request(OP_POP, 32'h0, 12'h000, 32'h0));
  endtask

  // Push a burst into the receive FIFO, then empty it through both read paths.
  task automatic test_rx_burst();
    int k;
    gap_limit = 0;
    for (k = 0; k < RX_BURST; k++) begin
      send_request(build_request(OP_PUSH, $urandom, $urandom_range(0, 4095), $urandom));
    end
    send_request(build_request(OP_LOAD, STATUS_ADDR, 12'h000, 32'h0));
    for (k = 0; k < RX_BURST + 1; k++) begin
      if (k % 2 == 0) send_request(build_request(OP_LOAD, DATA_ADDR, 12'h000, $urandom));
      else send_request(build_request(OP_CSR_RD, $urandom, CSR_GET_BYTE, $urandom));
    end
    send_request(build_request(OP_LOAD, STATUS_ADDR, 12'h000, 32'h0));
  endtask

  // Queue hex prints into the transmit FIFO back to back, then pop until the pops outnumber the bytes left.
  task automatic test_tx_burst();
    int k;
    gap_limit = 0;
    for (k = 0; k < TX_PRINTS; k++) begin
      send_request(build_request(OP_CSR_WR, $urandom, CSR_PRINT_HEX, $urandom));
    end
    for (k = 0; k < tx_level + 1; k++) begin
      send_request(build_request(OP_POP, $urandom, $urandom_range(0, 4095), $urandom));
    end
  endtask

  // Random traffic in blocks that lean toward filling or draining, with
  // stretches of back-to-back requests and one full pause halfway.
  task automatic test_random();
    int k;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 64 == 0) begin
        gap_limit = ($urandom_range(0, 3) == 0) ? 0 : 15;
        drain_mode = $urandom_range(0, 1);
      end
      if (k == RANDOM_ITEMS / 2) pause_until_drained();
      send_request(random_request());
    end
  endtask

  // Check every result strobe against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result %h arrived with no request pending", result);
      end else begin
        oldest_result = pending_results.pop_front();
        if (result.read_data !== oldest_result.read_data ||
            result.push_accepted !== oldest_result.push_accepted ||
            result.pop_valid !== oldest_result.pop_valid ||
            result.pop_byte !== oldest_result.pop_byte) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch on result %0d: expected rd=%h acc=%b pv=%b pb=%h,",
                     results_seen, oldest_result.read_data, oldest_result.push_accepted,
                     oldest_result.pop_valid, oldest_result.pop_byte);
            $display("  got rd=%h acc=%b pv=%b pb=%h", result.read_data,
                     result.push_accepted, result.pop_valid, result.pop_byte);
          end
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    tick_count++;
    if (tick_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending", tick_count,
               pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_rx_burst();
    test_tx_burst();
    test_random();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d loads, %0d stores, %0d CSR writes, %0d CSR reads, %0d pushes,",
             op_count[OP_LOAD], op_count[OP_STORE], op_count[OP_CSR_WR],
             op_count[OP_CSR_RD], op_count[OP_PUSH]);
    $display("%0d pops, %0d spare opcodes; %0d results checked, %0d refused, %0d dropped.",
             op_count[OP_POP], op_count[OP_RSVD6] + op_count[OP_RSVD7], results_seen,
             rx_refused, tx_dropped);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
